// ----- rtl/nmea_chk_pkg.sv -----
// Shared types, character codes and helpers for the NMEA sentence checker.
package nmea_chk_pkg;

    localparam int LINE_BYTES_DEF = 128;
    localparam int MAX_FIELDS_DEF = 31;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NO_DOLLAR = 3'd2,
        ST_NO_STAR   = 3'd3,
        ST_NO_SUM    = 3'd4,
        ST_BAD_SUM   = 3'd5,
        ST_OVERFLOW  = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        KIND_OTHER = 3'd0,
        KIND_GGA   = 3'd1,
        KIND_VTG   = 3'd2,
        KIND_RMC   = 3'd3,
        KIND_GPGSV = 3'd4,
        KIND_IISMD = 3'd5
    } t_kind;

    // Snapshot of the line held so far, handed to the evaluation logic.
    typedef struct packed {
        logic [5:0][7:0] hdr;
        logic [2:0][7:0] tail;
        logic [7:0]      xsum;
        logic            ge4;
        logic            ge6;
    } t_line;

    typedef struct packed {
        t_status    status;
        t_kind      kind;
        logic [4:0] fields;
        logic [7:0] cx;
        logic [7:0] rx;
        logic       upd;
    } t_result;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ----- rtl/nmea_chk_accum.sv -----
// Line accumulator: length, trailing carriage returns, checksum, comma count, header and tail bytes.
module nmea_chk_accum #(
    parameter int LINE_BYTES = nmea_chk_pkg::LINE_BYTES_DEF,
    parameter int MAX_FIELDS = nmea_chk_pkg::MAX_FIELDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_step,
    input  logic [7:0]                         i_byte,
    output nmea_chk_pkg::t_line                o_line,
    output logic [$clog2(MAX_FIELDS+1)-1:0]    o_comma,
    output logic                               o_is_lf,
    output logic                               o_ovf
);
    import nmea_chk_pkg::*;

    localparam int LEN_W = $clog2(LINE_BYTES);
    localparam int SUM_W = LEN_W + 1;
    localparam int CNT_W = $clog2(MAX_FIELDS + 1);

    logic [LEN_W-1:0]      r_len, n_len;
    logic [LEN_W-1:0]      r_pend, n_pend;
    logic [7:0]            r_xor, n_xor;
    logic [2:0][7:0]       r_tail, n_tail;
    logic [5:0][7:0]       r_hdr, n_hdr;
    logic [CNT_W-1:0]      r_comma, n_comma;

    logic [SUM_W-1:0] len_w, pend_w, pos_b, total;
    logic [SUM_W-1:0] cr_cnt;
    logic             is_cr;

    assign len_w   = SUM_W'(r_len);
    assign pend_w  = SUM_W'(r_pend);
    assign pos_b   = len_w + pend_w;
    assign total   = pos_b + SUM_W'(1);
    assign is_cr   = (i_byte == CH_CR);
    assign o_is_lf = (i_byte == CH_LF);
    assign o_ovf   = !o_is_lf && (total >= SUM_W'(LINE_BYTES - 1));

    // Carriage returns released together with the byte that lands after them;
    // only those that end up at least four places from the end enter the XOR.
    always_comb begin
        cr_cnt = '0;
        if (r_len != '0) begin
            if (pend_w >= SUM_W'(3)) cr_cnt = pend_w - SUM_W'(2);
        end else begin
            if (pend_w >= SUM_W'(4)) cr_cnt = pend_w - SUM_W'(3);
        end
    end

    always_comb begin
        n_len   = r_len;
        n_pend  = r_pend;
        n_xor   = r_xor;
        n_tail  = r_tail;
        n_hdr   = r_hdr;
        n_comma = r_comma;
        if (i_step) begin
            if (o_is_lf || o_ovf) begin
                n_len   = '0;
                n_pend  = '0;
                n_xor   = '0;
                n_tail  = '0;
                n_hdr   = '0;
                n_comma = '0;
            end else if (is_cr) begin
                n_pend = r_pend + LEN_W'(1);
            end else begin
                if (len_w >= SUM_W'(4)) n_xor = n_xor ^ r_tail[0];
                if (pend_w >= SUM_W'(1) && len_w >= SUM_W'(3)) n_xor = n_xor ^ r_tail[1];
                if (pend_w >= SUM_W'(2) && len_w >= SUM_W'(2)) n_xor = n_xor ^ r_tail[2];
                if (cr_cnt[0]) n_xor = n_xor ^ CH_CR;

                if (r_pend == '0) begin
                    n_tail = {i_byte, r_tail[2], r_tail[1]};
                end else if (r_pend == LEN_W'(1)) begin
                    n_tail = {i_byte, CH_CR, r_tail[2]};
                end else begin
                    n_tail = {i_byte, CH_CR, CH_CR};
                end

                for (int i = 0; i < 6; i++) begin
                    if (SUM_W'(i) >= len_w && SUM_W'(i) < pos_b) begin
                        n_hdr[i] = CH_CR;
                    end else if (SUM_W'(i) == pos_b) begin
                        n_hdr[i] = i_byte;
                    end
                end

                if (i_byte == CH_COMMA && r_comma < CNT_W'(MAX_FIELDS)) begin
                    n_comma = r_comma + CNT_W'(1);
                end

                n_len  = LEN_W'(total);
                n_pend = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_pend  <= '0;
            r_xor   <= '0;
            r_tail  <= '0;
            r_hdr   <= '0;
            r_comma <= '0;
        end else begin
            r_len   <= n_len;
            r_pend  <= n_pend;
            r_xor   <= n_xor;
            r_tail  <= n_tail;
            r_hdr   <= n_hdr;
            r_comma <= n_comma;
        end
    end

    assign o_line.hdr  = r_hdr;
    assign o_line.tail = r_tail;
    assign o_line.xsum = r_xor;
    assign o_line.ge4  = (r_len >= LEN_W'(4));
    assign o_line.ge6  = (r_len >= LEN_W'(6));
    assign o_comma     = r_comma;

endmodule

// ----- rtl/nmea_chk_eval.sv -----
// Line evaluation: status checks, checksum compare, sentence classification.
module nmea_chk_eval #(
    parameter int MAX_FIELDS = nmea_chk_pkg::MAX_FIELDS_DEF
) (
    input  nmea_chk_pkg::t_line               i_line,
    input  logic [$clog2(MAX_FIELDS+1)-1:0]   i_comma,
    input  logic                              i_ovf,
    output nmea_chk_pkg::t_result             o_res
);
    import nmea_chk_pkg::*;

    localparam int CNT_W = $clog2(MAX_FIELDS + 1);

    logic [4:0]       hi, lo;
    logic [7:0]       rx;
    logic [CNT_W-1:0] fields;
    logic [CNT_W+4:0] fields_w;
    logic             m_gga, m_vtg, m_rmc, m_gsv, m_smd;

    assign hi = hex_digit(i_line.tail[1]);
    assign lo = hex_digit(i_line.tail[2]);
    assign rx = lo[4] ? {hi[3:0], lo[3:0]} : {4'd0, hi[3:0]};

    assign fields   = (i_comma == CNT_W'(MAX_FIELDS)) ? CNT_W'(MAX_FIELDS)
                                                       : i_comma + CNT_W'(1);
    assign fields_w = {5'd0, fields};

    assign m_gga = i_line.ge6 && i_line.hdr[5:3] == {8'h41, 8'h47, 8'h47};
    assign m_vtg = i_line.ge6 && i_line.hdr[5:3] == {8'h47, 8'h54, 8'h56};
    assign m_rmc = i_line.ge6 && i_line.hdr[5:3] == {8'h43, 8'h4D, 8'h52};
    assign m_gsv = i_line.ge6 && i_line.hdr == {8'h56, 8'h53, 8'h47, 8'h50, 8'h47, CH_DOLLAR}
                   && fields >= CNT_W'(4);
    assign m_smd = i_line.ge6 && i_line.hdr == {8'h44, 8'h4D, 8'h53, 8'h49, 8'h49, CH_DOLLAR};

    always_comb begin
        o_res        = '0;
        o_res.status = ST_OK;
        o_res.kind   = KIND_OTHER;
        if (i_ovf) begin
            o_res.status = ST_OVERFLOW;
        end else if (!i_line.ge4) begin
            o_res.status = ST_SHORT;
        end else if (i_line.hdr[0] != CH_DOLLAR) begin
            o_res.status = ST_NO_DOLLAR;
        end else if (i_line.tail[0] != CH_STAR) begin
            o_res.status = ST_NO_STAR;
        end else begin
            o_res.cx = i_line.xsum;
            if (!hi[4]) begin
                o_res.status = ST_NO_SUM;
            end else if (rx != i_line.xsum) begin
                o_res.status = ST_BAD_SUM;
                o_res.rx     = rx;
            end else begin
                o_res.rx     = rx;
                o_res.fields = fields_w[4:0];
                if (m_gga) begin
                    o_res.kind = KIND_GGA;
                end else if (m_vtg) begin
                    o_res.kind = KIND_VTG;
                end else if (m_rmc) begin
                    o_res.kind = KIND_RMC;
                end else if (m_gsv) begin
                    o_res.kind = KIND_GPGSV;
                end else if (m_smd) begin
                    o_res.kind = KIND_IISMD;
                end
                o_res.upd = m_gga || m_rmc;
            end
        end
    end

endmodule

// ----- rtl/nmea_sentence_checker.sv -----
// NMEA sentence checker top level: input beat register, line logic, result register.
//
//  channel | dir | payload (tdata, low bits first)
//  --------+-----+-----------------------------------------------------------------
//  s_axis  | in  | [7:0] data_byte
//  m_axis  | out | [2:0] line_status, [5:3] sentence_kind, [10:6] field_count,
//          |     | [18:11] computed_checksum, [26:19] received_checksum,
//          |     | [27] position_update, [31:28] zero
//
// One byte is taken per cycle while the input is not stalled. A byte is held in
// the input register and updates the line state as it moves on; a line feed or
// an overflow writes a result into the output register, from which it is offered.
// Reset clears the line state and both valid flags. A result waiting in the
// output register stalls the input only when the next byte also makes a result.
module nmea_sentence_checker #(
    parameter int LINE_BYTES = nmea_chk_pkg::LINE_BYTES_DEF,
    parameter int MAX_FIELDS = nmea_chk_pkg::MAX_FIELDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // status, kind, fields, cx, rx, upd, pad
);
    import nmea_chk_pkg::*;

    localparam int CNT_W = $clog2(MAX_FIELDS + 1);

    logic             r_in_vld;
    logic [7:0]       r_in_byte;
    logic             r_out_vld;
    t_result          r_out;

    t_line            line;
    logic [CNT_W-1:0] comma;
    logic             is_lf, ovf, emits, step;
    t_result          res;

    assign emits = is_lf || ovf;
    assign step  = r_in_vld && (!emits || !r_out_vld || i_m_axis_tready);

    assign o_s_axis_tready = !r_in_vld || step;

    nmea_chk_accum #(
        .LINE_BYTES (LINE_BYTES),
        .MAX_FIELDS (MAX_FIELDS)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_line  (line),
        .o_comma (comma),
        .o_is_lf (is_lf),
        .o_ovf   (ovf)
    );

    nmea_chk_eval #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_eval (
        .i_line  (line),
        .i_comma (comma),
        .i_ovf   (ovf),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step && emits) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emits) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {4'd0, r_out.upd, r_out.rx, r_out.cx, r_out.fields,
                              r_out.kind, r_out.status};

endmodule

// ----- dv/nmea_sentence_checker_tb.sv -----
// Self-checking testbench for the NMEA sentence checker: byte stream in, line verdicts out.
module nmea_sentence_checker_tb;

    import nmea_chk_pkg::*;

    localparam int LINE_BYTES  = LINE_BYTES_DEF;
    localparam int MAX_FIELDS  = MAX_FIELDS_DEF;
    localparam int RANDOM_BYTES = 140;
    localparam int MIN_RANDOM_LINES = 8;
    localparam int TAIL_CYCLES = 8;
    localparam int QUIET_LIMIT = 4000;

    typedef enum int {
        SUM_UPPER,
        SUM_LOWER,
        SUM_ONE_DIGIT,
        SUM_WRONG,
        SUM_NOT_HEX,
        SUM_NO_STAR
    } t_sum_style;

    typedef struct {
        t_status    status;
        t_kind      kind;
        logic [4:0] fields;
        logic [7:0] cx;
        logic [7:0] rx;
        logic       upd;
    } t_verdict;

    // Tracks the line being received and holds the verdicts still owed by the block.
    class nmea_line_tracker;
        int unsigned line_len;
        logic [7:0]  xor_acc;
        logic [7:0]  tail [3];
        logic [7:0]  head [6];
        int unsigned commas;
        int unsigned cr_run;
        t_verdict    pending_verdicts [$];
        int unsigned lines_closed;
        int unsigned verdicts_seen;
        int unsigned mismatches;
        int unsigned status_hits [7];
        int unsigned kind_hits [6];

        function new();
            clear_line();
            lines_closed  = 0;
            verdicts_seen = 0;
            mismatches    = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
            foreach (kind_hits[i]) kind_hits[i] = 0;
        endfunction

        function void clear_line();
            line_len = 0;
            xor_acc  = 8'd0;
            commas   = 0;
            cr_run   = 0;
            foreach (tail[i]) tail[i] = 8'd0;
            foreach (head[i]) head[i] = 8'd0;
        endfunction

        function void push_char(logic [7:0] b, int unsigned pos);
            if (pos < 6) head[pos] = b;
            // The checksum only takes a character once three newer ones follow it.
            if (pos >= 4) xor_acc ^= tail[0];
            tail[0] = tail[1];
            tail[1] = tail[2];
            tail[2] = b;
            if (b == CH_COMMA && commas < MAX_FIELDS) commas++;
        endfunction

        function int hex_nibble(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
            return -1;
        endfunction

        function bit header_is(int unsigned len, int unsigned from, string s);
            if (len < from + s.len()) return 1'b0;
            for (int k = 0; k < s.len(); k++)
                if (head[from + k] != s[k]) return 1'b0;
            return 1'b1;
        endfunction

        function t_verdict close_line();
            t_verdict    v;
            int unsigned len;
            int unsigned nf;
            int          hi;
            int          lo;
            v.status = ST_OK;
            v.kind   = KIND_OTHER;
            v.fields = 5'd0;
            v.cx     = 8'd0;
            v.rx     = 8'd0;
            v.upd    = 1'b0;
            len = line_len - cr_run;
            if (len < 4) begin
                v.status = ST_SHORT;
            end else if (head[0] != CH_DOLLAR) begin
                v.status = ST_NO_DOLLAR;
            end else if (tail[0] != CH_STAR) begin
                v.status = ST_NO_STAR;
            end else begin
                v.cx = xor_acc;
                hi = hex_nibble(tail[1]);
                if (hi < 0) begin
                    v.status = ST_NO_SUM;
                end else begin
                    lo = hex_nibble(tail[2]);
                    v.rx = (lo < 0) ? 8'(hi) : 8'(hi * 16 + lo);
                    if (v.rx != v.cx) begin
                        v.status = ST_BAD_SUM;
                    end else begin
                        nf = (commas + 1 > MAX_FIELDS) ? MAX_FIELDS : commas + 1;
                        v.fields = 5'(nf);
                        if (header_is(len, 3, "GGA")) v.kind = KIND_GGA;
                        else if (header_is(len, 3, "VTG")) v.kind = KIND_VTG;
                        else if (header_is(len, 3, "RMC")) v.kind = KIND_RMC;
                        else if (header_is(len, 0, "$GPGSV") && nf >= 4) v.kind = KIND_GPGSV;
                        else if (header_is(len, 0, "$IISMD")) v.kind = KIND_IISMD;
                        v.upd = (v.kind == KIND_GGA || v.kind == KIND_RMC);
                    end
                end
            end
            return v;
        endfunction

        function void owe_verdict(t_verdict v);
            pending_verdicts.push_back(v);
            lines_closed++;
            status_hits[int'(v.status)]++;
            kind_hits[int'(v.kind)]++;
        endfunction

        function void take_byte(logic [7:0] b);
            t_verdict    v;
            int unsigned base;
            if (b == CH_LF) begin
                owe_verdict(close_line());
                clear_line();
                return;
            end
            line_len++;
            if (b == CH_CR) begin
                cr_run++;
            end else begin
                // Carriage returns followed by more text belong to the line after all.
                base = line_len - 1 - cr_run;
                for (int k = 0; k < cr_run; k++) push_char(CH_CR, base + k);
                push_char(b, base + cr_run);
                cr_run = 0;
            end
            if (line_len >= LINE_BYTES - 1) begin
                clear_line();
                v.status = ST_OVERFLOW;
                v.kind   = KIND_OTHER;
                v.fields = 5'd0;
                v.cx     = 8'd0;
                v.rx     = 8'd0;
                v.upd    = 1'b0;
                owe_verdict(v);
            end
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_verdict(logic [31:0] d);
            t_verdict want;
            string    diffs;
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("result %0d (%h) arrived with none outstanding",
                                 verdicts_seen, d));
                return;
            end
            want  = pending_verdicts.pop_front();
            diffs = "";
            if (d[2:0] != want.status)
                diffs = {diffs, $sformatf(" status %0d/%0d", d[2:0], want.status)};
            if (d[5:3] != want.kind)
                diffs = {diffs, $sformatf(" kind %0d/%0d", d[5:3], want.kind)};
            if (d[10:6] != want.fields)
                diffs = {diffs, $sformatf(" fields %0d/%0d", d[10:6], want.fields)};
            if (d[18:11] != want.cx)
                diffs = {diffs, $sformatf(" cx %h/%h", d[18:11], want.cx)};
            if (d[26:19] != want.rx)
                diffs = {diffs, $sformatf(" rx %h/%h", d[26:19], want.rx)};
            if (d[27] != want.upd)
                diffs = {diffs, $sformatf(" upd %b/%b", d[27], want.upd)};
            if (d[31:28] != 4'd0)
                diffs = {diffs, $sformatf(" pad %h/0", d[31:28])};
            if (diffs != "")
                report($sformatf("result %0d, got/expected:%s", verdicts_seen, diffs));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'd0;    // [7:0] data_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;           // status, kind, fields, cx, rx, upd, pad

    nmea_line_tracker tracker;
    logic [7:0]       line_buf [$];
    int               src_idle_pct = 0;
    int               snk_stall_pct = 0;
    int unsigned      bytes_sent = 0;

    nmea_sentence_checker #(
        .LINE_BYTES(LINE_BYTES),
        .MAX_FIELDS(MAX_FIELDS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Values seen here are the ones from before the edge, so every beat is taken once.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) tracker.take_byte(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready) tracker.check_verdict(o_m_axis_tdata);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timed out after %0d cycles without a beat.", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
        if (n < 10) return 8'("0") + 8'(n);
        return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] any_non_lf();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CH_LF) ? CH_CR : b;
    endfunction

    function automatic logic [7:0] pick_field_char();
        string set;
        set = "0123456789.ABCDEFNSEWmk-";
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic void put_byte(logic [7:0] b);
        line_buf.push_back(b);
    endfunction

    function automatic void put_text(string s);
        for (int k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
    endfunction

    function automatic void start_sentence();
        line_buf.delete();
        put_byte(CH_DOLLAR);
    endfunction

    // Appends the star (a hash for SUM_NO_STAR) and checksum digits, spelled or spoiled as the style asks.
    function automatic void put_sum(t_sum_style style);
        logic [7:0] x;
        x = 8'd0;
        for (int k = 1; k < line_buf.size(); k++) x ^= line_buf[k];
        case (style)
            SUM_LOWER: begin
                put_byte(CH_STAR);
                put_byte(hex_char(x[7:4], 1'b1));
                put_byte(hex_char(x[3:0], 1'b1));
            end
            SUM_ONE_DIGIT: begin
                put_byte(CH_STAR);
                if (x < 8'd16) begin
                    put_byte(hex_char(x[3:0], 1'b0));
                    put_byte("z");
                end else begin
                    put_byte(hex_char(x[7:4], 1'b0));
                    put_byte(hex_char(x[3:0], 1'b0));
                end
            end
            SUM_WRONG: begin
                x ^= 8'($urandom_range(1, 255));
                put_byte(CH_STAR);
                put_byte(hex_char(x[7:4], 1'b0));
                put_byte(hex_char(x[3:0], 1'b0));
            end
            SUM_NOT_HEX: begin
                put_byte(CH_STAR);
                put_byte(8'("G") + 8'($urandom_range(0, 19)));
                put_byte(hex_char(x[3:0], 1'b0));
            end
            SUM_NO_STAR: begin
                put_byte("#");
                put_byte(hex_char(x[7:4], 1'b0));
                put_byte(hex_char(x[3:0], 1'b0));
            end
            default: begin
                put_byte(CH_STAR);
                put_byte(hex_char(x[7:4], 1'b0));
                put_byte(hex_char(x[3:0], 1'b0));
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic flush_line(input int n_cr, input bit with_lf);
        repeat (n_cr) put_byte(CH_CR);
        if (with_lf) put_byte(CH_LF);
        foreach (line_buf[k]) send_byte(line_buf[k]);
        line_buf.delete();
    endtask

    // The first edge lets the monitor note the last beat before the queue is read.
    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_directed();
        start_sentence();
        put_text("GPGGA,123519,4807.038,N,01131.000,E");
        put_sum(SUM_UPPER);
        flush_line(1, 1);
        start_sentence();
        put_text("GPVTG,054.7,T,034.4,M");
        put_sum(SUM_LOWER);
        flush_line(0, 1);
        start_sentence();
        put_text("GNRMC,225446,A");
        put_sum(SUM_UPPER);
        flush_line(2, 1);
        start_sentence();
        put_text("GPGSV,3,1,11");
        put_sum(SUM_UPPER);
        flush_line(1, 1);
        // Too few fields to count as a satellite view sentence.
        start_sentence();
        put_text("GPGSV,3,1");
        put_sum(SUM_UPPER);
        flush_line(1, 1);
        start_sentence();
        put_text("IISMD");
        put_sum(SUM_LOWER);
        flush_line(0, 1);
        start_sentence();
        put_text("ABGGA,7");
        put_sum(SUM_UPPER);
        flush_line(0, 1);
        start_sentence();
        put_text("GPXDR,A");
        put_sum(SUM_UPPER);
        flush_line(0, 1);
        // Checksum small enough to travel as a single digit.
        start_sentence();
        put_text("AB");
        put_sum(SUM_ONE_DIGIT);
        flush_line(0, 1);
        // Shortest line that can pass.
        start_sentence();
        put_sum(SUM_UPPER);
        flush_line(1, 1);
        line_buf.delete();
        flush_line(0, 1);
        start_sentence();
        put_text("*");
        flush_line(3, 1);
        line_buf.delete();
        flush_line(4, 1);
        line_buf.delete();
        put_text("GPGGA,1*00");
        flush_line(0, 1);
        start_sentence();
        put_text("GPGGA,1,2,3");
        flush_line(0, 1);
        start_sentence();
        put_text("GPGGA,1");
        put_sum(SUM_NO_STAR);
        flush_line(0, 1);
        start_sentence();
        put_text("GPGGA,1");
        put_sum(SUM_NOT_HEX);
        flush_line(0, 1);
        start_sentence();
        put_text("GPRMC,2");
        put_sum(SUM_WRONG);
        flush_line(1, 1);
        // A carriage return inside the header spoils the kind but not the checksum.
        start_sentence();
        put_text("GP");
        put_byte(CH_CR);
        put_text("GGA,1");
        put_sum(SUM_UPPER);
        flush_line(0, 1);
        start_sentence();
        put_text("GPRMC,");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h80);
        put_text(",1");
        put_sum(SUM_UPPER);
        flush_line(0, 1);
        start_sentence();
        put_text("GPGGA");
        repeat (40) put_byte(CH_COMMA);
        put_sum(SUM_UPPER);
        flush_line(0, 1);
        // Overflow without a line feed; the next sentence must start clean.
        line_buf.delete();
        repeat (LINE_BYTES - 1) put_byte("A");
        flush_line(0, 0);
        start_sentence();
        put_text("IISMD,4");
        put_sum(SUM_UPPER);
        flush_line(0, 1);
        line_buf.delete();
        flush_line(LINE_BYTES - 1, 1);
    endtask

    task automatic random_sentence(input bit mangle);
        int n_fields;
        int r;
        int pos;
        t_sum_style style;
        start_sentence();
        case ($urandom_range(0, 4))
            0: put_text("GP");
            1: put_text("GN");
            2: put_text("II");
            default: repeat (2) put_byte(8'("A") + 8'($urandom_range(0, 25)));
        endcase
        case ($urandom_range(0, 6))
            0: put_text("GGA");
            1: put_text("VTG");
            2: put_text("RMC");
            3: put_text("GSV");
            4: put_text("SMD");
            default: repeat (3) put_byte(8'("A") + 8'($urandom_range(0, 25)));
        endcase
        n_fields = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
        repeat (n_fields) begin
            put_byte(CH_COMMA);
            repeat ($urandom_range(0, 4)) begin
                if ($urandom_range(0, 7) == 0) put_byte(any_non_lf());
                else put_byte(pick_field_char());
            end
        end
        r = $urandom_range(0, 99);
        if (r < 35) style = SUM_UPPER;
        else if (r < 55) style = SUM_LOWER;
        else if (r < 70) style = SUM_ONE_DIGIT;
        else if (r < 82) style = SUM_WRONG;
        else if (r < 91) style = SUM_NOT_HEX;
        else style = SUM_NO_STAR;
        put_sum(style);
        if (mangle) begin
            if ($urandom_range(0, 1)) begin
                pos = $urandom_range(0, line_buf.size() - 1);
                line_buf[pos] = any_non_lf();
            end else begin
                repeat ($urandom_range(1, 3)) void'(line_buf.pop_back());
            end
        end
        flush_line($urandom_range(0, 2), 1'b1);
    endtask

    task automatic random_line();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            random_sentence(1'b0);
        end else if (r < 82) begin
            random_sentence(1'b1);
        end else if (r < 98) begin
            // Raw noise, line feeds included.
            line_buf.delete();
            repeat ($urandom_range(0, 12)) put_byte(8'($urandom_range(0, 255)));
            flush_line(0, 1'b1);
        end else begin
            line_buf.delete();
            repeat ($urandom_range(LINE_BYTES - 1, LINE_BYTES + 8)) put_byte(any_non_lf());
            flush_line(0, 1'b1);
        end
    endtask

    initial begin
        int unsigned phase_start;
        int unsigned random_start;
        tracker = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        wait_for_results();
        random_start = tracker.lines_closed;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
                default: begin src_idle_pct = 25; snk_stall_pct = 25; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < RANDOM_BYTES / 4 ||
                   (phase == 3 && tracker.lines_closed - random_start < MIN_RANDOM_LINES))
                random_line();
            wait_for_results();
        end
        $display("Sent %0d bytes under four handshake mixes; %0d verdicts checked.",
                 bytes_sent, tracker.verdicts_seen);
        $write("Status ok/short/no$/no*/nosum/badsum/ovf %0d/%0d/%0d/%0d/%0d/%0d/%0d,",
               tracker.status_hits[0], tracker.status_hits[1], tracker.status_hits[2],
               tracker.status_hits[3], tracker.status_hits[4], tracker.status_hits[5],
               tracker.status_hits[6]);
        $display(" kinds other/GGA/VTG/RMC/GSV/SMD %0d/%0d/%0d/%0d/%0d/%0d",
                 tracker.kind_hits[0], tracker.kind_hits[1], tracker.kind_hits[2],
                 tracker.kind_hits[3], tracker.kind_hits[4], tracker.kind_hits[5]);
        if (tracker.mismatches == 0 && tracker.pending_verdicts.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/nmea_chk_pkg.sv
rtl/nmea_chk_accum.sv
rtl/nmea_chk_eval.sv
rtl/nmea_sentence_checker.sv
dv/nmea_sentence_checker_tb.sv
